### src/chi_square_histogram_test_macros.svh
// Assertion macros for the chi-square histogram test block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CHI_SQUARE_HISTOGRAM_TEST_MACROS_SVH
`define CHI_SQUARE_HISTOGRAM_TEST_MACROS_SVH

// prop must hold at every clock edge outside reset
`define CHISQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true outside reset
`define CHISQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/chisq_pkg.sv
// Package for the chi-square histogram test: field widths, defaults and
// sequencer state type. No dependencies.
`default_nettype none

package chisq_pkg;

  localparam int unsigned SampleW     = 16;
  localparam int unsigned CountW      = 21;
  localparam int unsigned SumW        = 42;
  localparam int unsigned ChiW        = 49;
  localparam int unsigned DivW        = SumW + 8;
  localparam int unsigned DivCntW     = $clog2(DivW);
  localparam int unsigned BinsDefault = 100;

  localparam logic [CountW-1:0]  RunReset = CountW'(10000);
  localparam logic [CountW-1:0]  CountMax = '1;
  localparam logic [SumW-1:0]    SumMax   = '1;
  localparam logic [ChiW-1:0]    ChiMax   = '1;
  localparam logic [DivCntW-1:0] DivLast  = DivCntW'(DivW - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_INC,
    S_EDIV,
    S_SWEEP,
    S_DRAIN,
    S_CDIV,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

### src/chisq_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package needed.
`default_nettype none

module chisq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/chi_square_histogram_test.sv
// Chi-square uniformity test: bins samples in a histogram RAM, then sweeps it
// for the squared deviation sum and divides with one shared serial divider.
// Depends on chisq_pkg, chisq_ram and chi_square_histogram_test_macros.svh.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid_i, in_stall_o, sample_i          | request in
//   out      | out_valid_o, out_stall_i, sum_sq_dev_o,   | request out
//            | chi_square_q8_o, expected_zero_o          |
//   cfg      | cfg_we_i, cfg_wdata_i (samples_per_run)   | write only
//
// A sample goes through S_RD and S_INC: bin RAM read, then read-modify-write of the count.
// Run end runs the divider for E, sweeps the bins and drains the square
// pipeline, runs the divider again for chi-square unless E is 0, and then
// emits the result.
// After reset a clearing pass zeroes the histogram while in is stalled.
// The result sits in an output register; a full one stalls only the next run end.
`default_nettype none
`include "chi_square_histogram_test_macros.svh"

module chi_square_histogram_test #(
  parameter int unsigned BINS = chisq_pkg::BinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [chisq_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [chisq_pkg::SampleW-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [chisq_pkg::SumW-1:0]    sum_sq_dev_o,
  output logic [chisq_pkg::ChiW-1:0]    chi_square_q8_o,
  output logic                          expected_zero_o
);

  import chisq_pkg::*;

  localparam int unsigned BinW  = $clog2(BINS);
  localparam int unsigned BinsW = $clog2(BINS + 1);
  localparam int unsigned ProdW = SampleW + BinsW;
  localparam logic [BinW-1:0] BinLast = BinW'(BINS - 1);

  state_e state_q, state_d;
  logic [CountW-1:0] run_q;
  logic [BinW-1:0]   addr_q, addr_d;
  logic [BinW-1:0]   bin_q, bin_d;
  logic [CountW-1:0] seen_q, seen_d;
  logic [CountW-1:0] e_q, e_d;
  logic [SumW-1:0]   acc_q, acc_d;
  logic [DivW-1:0]   div_dvd_q, div_dvd_d;
  logic [CountW-1:0] div_rem_q, div_rem_d;
  logic [CountW-1:0] div_dvs_q, div_dvs_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [SumW-1:0]   sum_out_q, sum_out_d;
  logic [ChiW-1:0]   chi_out_q, chi_out_d;
  logic              ez_out_q, ez_out_d;

  logic              p1_vld_q, p2_vld_q, p3_vld_q;
  logic [BinW-1:0]   p1_addr_q;
  logic [CountW-1:0] d_q;
  logic [SumW-1:0]   sq_q;
  logic              issue;

  logic              ram_we;
  logic [BinW-1:0]   ram_waddr, ram_raddr;
  logic [CountW-1:0] ram_wdata, ram_rdata;

  logic [ProdW-1:0]  prod;
  logic [CountW-1:0] cnt_inc, seen_inc, dev;
  logic [SumW:0]     acc_sum;
  logic [CountW:0]   rem_sh, rem_sub;
  logic              rem_ge;
  logic [CountW-1:0] rem_nx;
  logic [DivW-1:0]   dvd_nx;

  chisq_ram #(
    .Width(CountW),
    .Depth(BINS)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign prod     = ProdW'(sample_i) * ProdW'(BINS);
  assign cnt_inc  = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + 1'b1;
  assign seen_inc = (seen_q == CountMax) ? seen_q : seen_q + 1'b1;
  assign dev      = (ram_rdata >= e_q) ? ram_rdata - e_q : e_q - ram_rdata;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, sq_q};

  // restoring divider step
  assign rem_sh  = {div_rem_q, div_dvd_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, div_dvs_q};
  assign rem_ge  = rem_sh >= {1'b0, div_dvs_q};
  assign rem_nx  = rem_ge ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
  assign dvd_nx  = {div_dvd_q[DivW-2:0], rem_ge};

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    bin_d       = bin_q;
    seen_d      = seen_q;
    e_d         = e_q;
    acc_d       = acc_q;
    div_dvd_d   = div_dvd_q;
    div_rem_d   = div_rem_q;
    div_dvs_d   = div_dvs_q;
    div_cnt_d   = div_cnt_q;
    sum_out_d   = sum_out_q;
    chi_out_d   = chi_out_q;
    ez_out_d    = ez_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    issue       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    ram_raddr   = bin_q;

    // sweep pipeline: clear the bin just read, accumulate squares
    if (p1_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = p1_addr_q;
    end
    if (p3_vld_q) begin
      acc_d = acc_sum[SumW] ? SumMax : acc_sum[SumW-1:0];
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == BinLast) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          bin_d   = prod[SampleW +: BinW];
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_INC;
      end
      S_INC: begin
        ram_we    = 1'b1;
        ram_waddr = bin_q;
        ram_wdata = cnt_inc;
        seen_d    = seen_inc;
        if (seen_inc >= run_q) begin
          div_dvd_d = DivW'(run_q);
          div_rem_d = '0;
          div_dvs_d = CountW'(BINS);
          div_cnt_d = '0;
          state_d   = S_EDIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EDIV: begin
        div_dvd_d = dvd_nx;
        div_rem_d = rem_nx;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivLast) begin
          e_d     = dvd_nx[CountW-1:0];
          acc_d   = '0;
          addr_d  = '0;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ram_raddr = addr_q;
        issue     = 1'b1;
        addr_d    = addr_q + 1'b1;
        if (addr_q == BinLast) begin
          addr_d  = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q && !p3_vld_q) begin
          seen_d = '0;
          if (e_q == '0) begin
            state_d = S_EMIT;
          end else begin
            div_dvd_d = {acc_q, 8'h00};
            div_rem_d = '0;
            div_dvs_d = e_q;
            div_cnt_d = '0;
            state_d   = S_CDIV;
          end
        end
      end
      S_CDIV: begin
        div_dvd_d = dvd_nx;
        div_rem_d = rem_nx;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivLast) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          sum_out_d   = acc_q;
          ez_out_d    = (e_q == '0);
          if (e_q == '0) begin
            chi_out_d = '0;
          end else if (div_dvd_q[DivW-1]) begin
            chi_out_d = ChiMax;
          end else begin
            chi_out_d = div_dvd_q[ChiW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      run_q       <= RunReset;
      addr_q      <= '0;
      seen_q      <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        run_q <= cfg_wdata_i;
      end
      addr_q      <= addr_d;
      seen_q      <= seen_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      p1_vld_q    <= issue;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    e_q       <= e_d;
    acc_q     <= acc_d;
    div_dvd_q <= div_dvd_d;
    div_rem_q <= div_rem_d;
    div_dvs_q <= div_dvs_d;
    sum_out_q <= sum_out_d;
    chi_out_q <= chi_out_d;
    ez_out_q  <= ez_out_d;
    p1_addr_q <= addr_q;
    d_q       <= dev;
    sq_q      <= SumW'(d_q) * SumW'(d_q);
  end

  assign out_valid_o     = out_valid_q;
  assign sum_sq_dev_o    = sum_out_q;
  assign chi_square_q8_o = chi_out_q;
  assign expected_zero_o = ez_out_q;

  `CHISQ_ASSERT(a_accept_reads,
                (in_valid_i && !in_stall_o) |=> (state_q == S_RD),
                "accepted sample did not start a bin read")
  `CHISQ_ASSERT(a_idle_drained,
                (state_q == S_IDLE) |-> (!p1_vld_q && !p2_vld_q && !p3_vld_q),
                "sweep pipeline busy while idle")
  `CHISQ_ASSERT_NEVER(a_zero_e_chi,
                      out_valid_o && expected_zero_o && (chi_square_q8_o != '0),
                      "nonzero chi-square with zero expected count")

endmodule

`default_nettype wire

### dv/tb_chi_square_histogram_test.sv
// Testbench for chi_square_histogram_test: directed table, then random runs of
// samples, all results checked in order against a histogram predictor or the table.
// Depends on chisq_pkg and the chi_square_histogram_test RTL.
`default_nettype none

module tb_chi_square_histogram_test;
  import chisq_pkg::*;

  localparam int unsigned Bins        = BinsDefault;
  localparam int unsigned SampleGoal  = 1750;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned IdleLimit   = 8000;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    logic [SumW-1:0] sum;
    logic [ChiW-1:0] chi;
    logic            ez;
  } chi_result_t;

  typedef struct {
    row_kind_e       kind;
    logic [31:0]     value;
    bit              typed;
    logic [SumW-1:0] sum;
    logic [ChiW-1:0] chi;
    logic            ez;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SumW-1:0]     sum_sq_dev_o;
  logic [ChiW-1:0]     chi_square_q8_o;
  logic                expected_zero_o;

  chi_square_histogram_test dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sum_sq_dev_o    (sum_sq_dev_o),
    .chi_square_q8_o (chi_square_q8_o),
    .expected_zero_o (expected_zero_o)
  );

  // predictor state
  logic [CountW-1:0] hist_count [Bins];
  logic [CountW-1:0] seen_count;
  logic [CountW-1:0] run_len;

  chi_result_t due_results [$];
  chi_result_t got_want;
  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned idle_cycles    = 0;
  bit          calm           = 1'b0;
  bit          hold_arm       = 1'b0;
  bit          hold_taken     = 1'b0;
  int unsigned rx_hold        = 0;
  int unsigned rx_free        = 0;

  dir_row_t dir_rows [20] = '{
    '{ROW_SAMPLE, 32'h0000, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h028F, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0290, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_CFG,    32'd1,    1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h8000, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF, 1'b1, 42'd1, 49'd0, 1'b1},
    '{ROW_CFG,    32'd0,    1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0000, 1'b1, 42'd1, 49'd0, 1'b1},
    '{ROW_SAMPLE, 32'h1234, 1'b1, 42'd1, 49'd0, 1'b1},
    '{ROW_CFG,    32'd2,    1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0001, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0002, 1'b1, 42'd4, 49'd0, 1'b1},
    '{ROW_CFG,    32'h1FFFFF, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'hAAAA, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h5555, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'h7FFF, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_CFG,    32'd3,    1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFE, 1'b0, 42'd0, 49'd0, 1'b0},
    '{ROW_CFG,    32'd100,  1'b0, 42'd0, 49'd0, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // bins one sample; returns 1 and the run result when it closes a run
  function automatic bit bin_sample(input logic [SampleW-1:0] s, output chi_result_t res);
    int unsigned       b;
    logic [CountW-1:0] e;
    logic [63:0]       acc;
    logic [63:0]       d;
    logic [63:0]       q;
    b = (32'(s) * Bins) >> 16;
    if (b < Bins && hist_count[b] != CountMax) hist_count[b] = hist_count[b] + 1'b1;
    if (seen_count != CountMax) seen_count = seen_count + 1'b1;
    if (seen_count < run_len) return 1'b0;
    e = run_len / CountW'(Bins);
    acc = '0;
    for (int i = 0; i < Bins; i++) begin
      d = (hist_count[i] >= e) ? 64'(hist_count[i] - e) : 64'(e - hist_count[i]);
      acc = acc + d * d;
    end
    if (acc > 64'(SumMax)) acc = 64'(SumMax);
    if (e == '0) begin
      q = '0;
    end else begin
      q = (acc << 8) / 64'(e);
      if (q > 64'(ChiMax)) q = 64'(ChiMax);
    end
    res.sum = acc[SumW-1:0];
    res.chi = q[ChiW-1:0];
    res.ez  = (e == '0);
    for (int i = 0; i < Bins; i++) hist_count[i] = '0;
    seen_count = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [SampleW-1:0] next_sample(input int unsigned skew,
                                                     input logic [SampleW-1:0] lo);
    logic [SampleW-1:0] edges [6];
    edges = '{16'h0000, 16'hFFFF, 16'h028F, 16'h0290, 16'h7FFF, 16'h8000};
    case (skew)
      1: begin
        return lo + SampleW'($urandom_range(0, 1500));
      end
      2: begin
        if ($urandom_range(0, 1)) return edges[$urandom_range(0, 5)];
        return SampleW'($urandom_range(0, 65535));
      end
      default: begin
        return SampleW'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // offers one sample until accepted; returns at the accepting edge
  task automatic send_sample(input logic [SampleW-1:0] s, output bit closed,
                             output chi_result_t res);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    closed = bin_sample(s, res);
  endtask

  task automatic send_checked(input logic [SampleW-1:0] s);
    bit          closed;
    chi_result_t res;
    send_sample(s, closed, res);
    if (closed) due_results.push_back(res);
  endtask

  task automatic write_run_len(input logic [CountW-1:0] v);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    run_len = v;
  endtask

  task automatic run_directed();
    bit          closed;
    chi_result_t res;
    for (int i = 0; i < 20; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_run_len(dir_rows[i].value[CountW-1:0]);
      end else begin
        send_sample(dir_rows[i].value[SampleW-1:0], closed, res);
        if (closed) begin
          if (dir_rows[i].typed) begin
            res.sum = dir_rows[i].sum;
            res.chi = dir_rows[i].chi;
            res.ez  = dir_rows[i].ez;
          end
          due_results.push_back(res);
        end
      end
    end
  endtask

  task automatic run_random();
    int unsigned        r;
    int unsigned        n;
    int unsigned        skew;
    logic [CountW-1:0]  v;
    logic [SampleW-1:0] lo;
    while (sent_count < SampleGoal) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        v = CountW'($urandom_range(0, 1));
        n = $urandom_range(5, 30);
      end else if (r < 22) begin
        v = CountW'($urandom_range(2, 99));
        n = $urandom_range(v / 2 + 1, 2 * v + 5);
      end else if (r < 28) begin
        v = $urandom_range(0, 1) ? CountMax : CountW'($urandom_range(1000, 1048576));
        n = $urandom_range(1, 150);
      end else if (r < 35) begin
        v = CountW'(100 * $urandom_range(1, 2));
        n = v + $urandom_range(0, 20);
      end else begin
        v = CountW'($urandom_range(100, 350));
        n = $urandom_range(v / 2, 2 * v);
      end
      r    = $urandom_range(0, 9);
      skew = (r < 6) ? 0 : (r < 8) ? 1 : 2;
      lo   = SampleW'($urandom_range(0, 65535));
      write_run_len(v);
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n && sent_count < SampleGoal; k++) begin
        send_checked(next_sample(skew, lo));
      end
    end
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < Bins; i++) hist_count[i] = '0;
    seen_count = '0;
    run_len    = RunReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    // back-to-back single-sample runs while the receiver holds off
    write_run_len(CountW'(1));
    calm     = 1'b1;
    hold_arm = 1'b1;
    for (int k = 0; k < 20; k++) send_checked(SampleW'($urandom_range(0, 65535)));
    calm = 1'b0;
    run_random();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_arm && !hold_taken) begin
      hold_taken = 1'b1;
      rx_hold    = HoldCycles;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else if (rx_free > 0) begin
      rx_free--;
      out_stall_i <= 1'b0;
    end else begin
      rx_hold = pick_gap();
      rx_free = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 30);
      out_stall_i <= 1'b0;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result sum=%0d chi=%0d ez=%0b", $time,
                 sum_sq_dev_o, chi_square_q8_o, expected_zero_o);
        mismatch_count++;
      end else begin
        got_want = due_results.pop_front();
        if (sum_sq_dev_o !== got_want.sum) begin
          $display("%0t: sum_sq_dev expected %0d actual %0d", $time, got_want.sum,
                   sum_sq_dev_o);
          mismatch_count++;
        end
        if (chi_square_q8_o !== got_want.chi) begin
          $display("%0t: chi_square_q8 expected %0d actual %0d", $time, got_want.chi,
                   chi_square_q8_o);
          mismatch_count++;
        end
        if (expected_zero_o !== got_want.ez) begin
          $display("%0t: expected_zero expected %0b actual %0b", $time, got_want.ez,
                   expected_zero_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/chisq_pkg.sv
src/chisq_ram.sv
src/chi_square_histogram_test.sv
dv/tb_chi_square_histogram_test.sv
